FILE: rtl/abs_pkg.sv
package abs_pkg;

  typedef enum logic [2:0] {
    CmdBootSelect = 3'd0,
    CmdMarkActive = 3'd1,
    CmdUnbootable = 3'd2,
    CmdSuccessful = 3'd3,
    CmdSlotInfo   = 3'd4,
    CmdOneShot    = 3'd5,
    CmdLoad       = 3'd6,
    CmdUnused     = 3'd7
  } cmd_e;

  localparam logic [1:0] SlotA       = 2'd0;
  localparam logic [1:0] SlotB       = 2'd1;
  localparam logic [1:0] SlotR       = 2'd2;
  localparam logic [1:0] SlotInvalid = 2'd3;

  typedef struct packed {
    logic [2:0] command;
    logic [1:0] slot;
    logic       update_store;
    logic       enable_flag;
    logic [7:0] load_priority;
    logic [7:0] load_tries;
    logic       load_success;
    logic       load_oneshot;
    logic       load_valid;
  } cmd_t;

  typedef struct packed {
    logic       status;
    logic [1:0] boot_slot;
    logic       marked_successful;
    logic       slot_bootable;
    logic       slot_active;
    logic [7:0] tries_left;
    logic       changed;
  } res_t;

  typedef struct packed {
    logic [1:0][7:0] pri;
    logic [1:0][7:0] tries;
    logic [1:0]      succ;
    logic            os;
  } meta_t;

  typedef struct packed {
    logic  we;
    meta_t meta;
  } store_upd_t;

  function automatic meta_t meta_defaults(input logic [7:0] max_pri, input logic [7:0] max_tries);
    meta_t m;
    m.pri[0]   = max_pri;
    m.pri[1]   = max_pri - 8'd1;
    m.tries[0] = max_tries;
    m.tries[1] = max_tries;
    m.succ     = 2'b00;
    m.os       = 1'b0;
    return m;
  endfunction

endpackage

FILE: rtl/abs_if.sv
interface abs_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [1:0] slot;
  logic       update_store;
  logic       enable_flag;
  logic [7:0] load_priority;
  logic [7:0] load_tries;
  logic       load_success;
  logic       load_oneshot;
  logic       load_valid;

  modport source (
    output valid, command, slot, update_store, enable_flag, load_priority, load_tries,
           load_success, load_oneshot, load_valid,
    input  ready
  );
  modport sink (
    input  valid, command, slot, update_store, enable_flag, load_priority, load_tries,
           load_success, load_oneshot, load_valid,
    output ready
  );
endinterface

interface abs_res_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic [1:0] boot_slot;
  logic       marked_successful;
  logic       slot_bootable;
  logic       slot_active;
  logic [7:0] tries_left;
  logic       changed;

  modport source (
    output valid, status, boot_slot, marked_successful, slot_bootable, slot_active,
           tries_left, changed,
    input  ready
  );
  modport sink (
    input  valid, status, boot_slot, marked_successful, slot_bootable, slot_active,
           tries_left, changed,
    output ready
  );
endinterface

FILE: rtl/abs_norm.sv
module abs_norm #(
  parameter int MAX_PRIORITY = 15,
  parameter int MAX_TRIES    = 7
) (
  input  logic [7:0] pri_i,
  input  logic [7:0] tries_i,
  input  logic       succ_i,
  output logic [7:0] pri_o,
  output logic [7:0] tries_o,
  output logic       succ_o
);

  localparam logic [7:0] MaxPri   = 8'(MAX_PRIORITY);
  localparam logic [7:0] MaxTries = 8'(MAX_TRIES);

  always_comb begin
    if (pri_i == 8'd0 || (tries_i == 8'd0 && !succ_i)) begin
      pri_o   = 8'd0;
      tries_o = 8'd0;
      succ_o  = 1'b0;
    end else begin
      pri_o   = (pri_i > MaxPri) ? MaxPri : pri_i;
      tries_o = tries_i;
      succ_o  = succ_i;
      if (tries_i != 8'd0 && succ_i) begin
        tries_o = MaxTries;
        succ_o  = 1'b0;
      end else if (tries_i > MaxTries) begin
        tries_o = MaxTries;
      end
    end
  end

endmodule

FILE: rtl/abs_exec.sv
module abs_exec import abs_pkg::*; #(
  parameter int MAX_PRIORITY = 15,
  parameter int MAX_TRIES    = 7
) (
  input  cmd_t       cmd_i,
  input  meta_t      store_i,
  output res_t       res_o,
  output store_upd_t upd_o
);

  localparam logic [7:0] MaxPri   = 8'(MAX_PRIORITY);
  localparam logic [7:0] MaxTries = 8'(MAX_TRIES);

  meta_t      w;
  meta_t      nxt;
  logic [1:0] boot_ok;
  logic       hi;
  logic [1:0] act_slot;
  logic       sel;
  logic       we;

  assign w.os = store_i.os;

  for (genvar i = 0; i < 2; i++) begin : g_norm
    abs_norm #(
      .MAX_PRIORITY(MAX_PRIORITY),
      .MAX_TRIES   (MAX_TRIES)
    ) u_norm (
      .pri_i  (store_i.pri[i]),
      .tries_i(store_i.tries[i]),
      .succ_i (store_i.succ[i]),
      .pri_o  (w.pri[i]),
      .tries_o(w.tries[i]),
      .succ_o (w.succ[i])
    );
    assign boot_ok[i] = (w.pri[i] != 8'd0) && (w.succ[i] || w.tries[i] != 8'd0);
  end

  assign hi       = w.pri[1] > w.pri[0];
  assign act_slot = boot_ok[hi] ? {1'b0, hi} : SlotR;
  assign sel      = cmd_i.slot[0];

  always_comb begin
    res_o = '0;
    nxt   = w;
    we    = 1'b0;
    case (cmd_e'(cmd_i.command))
      CmdBootSelect: begin
        if (w.os && cmd_i.update_store) begin
          nxt.os          = 1'b0;
          we              = 1'b1;
          res_o.boot_slot = SlotR;
        end else begin
          res_o.boot_slot = act_slot;
          if (act_slot != SlotR) begin
            res_o.marked_successful = w.succ[hi];
            if (cmd_i.update_store && !w.succ[hi]) begin
              nxt.tries[hi] = w.tries[hi] - 8'd1;
            end
          end
          we = cmd_i.update_store;
        end
      end
      CmdMarkActive: begin
        if (cmd_i.slot[1]) begin
          res_o.status = 1'b1;
        end else begin
          nxt.pri[sel]   = MaxPri;
          nxt.tries[sel] = MaxTries;
          nxt.succ[sel]  = 1'b0;
          if (w.pri[~sel] == MaxPri) begin
            nxt.pri[~sel] = MaxPri - 8'd1;
          end
          we = 1'b1;
        end
      end
      CmdUnbootable: begin
        if (cmd_i.slot[1]) begin
          res_o.status = 1'b1;
        end else begin
          nxt.pri[sel]   = 8'd0;
          nxt.tries[sel] = 8'd0;
          nxt.succ[sel]  = 1'b0;
          we             = 1'b1;
        end
      end
      CmdSuccessful: begin
        if (cmd_i.slot[1] || !boot_ok[sel]) begin
          res_o.status = 1'b1;
        end else begin
          nxt.tries[sel] = 8'd0;
          nxt.succ[sel]  = 1'b1;
          we             = 1'b1;
        end
      end
      CmdSlotInfo: begin
        if (cmd_i.slot == SlotInvalid) begin
          res_o.status = 1'b1;
        end else begin
          res_o.slot_active = act_slot == cmd_i.slot;
          if (cmd_i.slot == SlotR) begin
            res_o.slot_bootable     = 1'b1;
            res_o.marked_successful = 1'b1;
          end else begin
            res_o.slot_bootable     = boot_ok[sel];
            res_o.marked_successful = w.succ[sel];
            res_o.tries_left        = w.tries[sel];
          end
        end
      end
      CmdOneShot: begin
        nxt.os = cmd_i.enable_flag;
        we     = 1'b1;
      end
      CmdLoad: begin
        if (!cmd_i.load_valid) begin
          nxt = meta_defaults(MaxPri, MaxTries);
          we  = 1'b1;
        end else if (cmd_i.slot[1]) begin
          res_o.status = 1'b1;
        end else begin
          nxt            = store_i;
          nxt.pri[sel]   = cmd_i.load_priority;
          nxt.tries[sel] = cmd_i.load_tries;
          nxt.succ[sel]  = cmd_i.load_success;
          nxt.os         = cmd_i.load_oneshot;
          we             = 1'b1;
        end
      end
      default: begin
        res_o.status = 1'b1;
      end
    endcase
    res_o.changed = we && (nxt != store_i);
    upd_o.we      = we;
    upd_o.meta    = nxt;
  end

endmodule

FILE: rtl/ab_boot_slot_selector.sv
// Channel  Dir  Interface          Content
// cmd_i    in   abs_cmd_if.sink    command, slot and raw load data
// res_o    out  abs_res_if.source  status, chosen slot, slot info, changed flag
//
// One command a cycle unless res_o stalls. The command register feeds normalize/execute
// logic and the result register, which drives res_o; the metadata store is written at
// the edge where the command moves to res_o.
// A stalled res_o holds the result and the command register; cmd_i is ready
// while the command register is empty or moving on.
// Reset loads the default metadata and empties both registers.
module ab_boot_slot_selector import abs_pkg::*; #(
  parameter int MAX_PRIORITY = 15,
  parameter int MAX_TRIES    = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  abs_cmd_if.sink          cmd_i,
  abs_res_if.source        res_o
);

  localparam logic [7:0] MaxPri   = 8'(MAX_PRIORITY);
  localparam logic [7:0] MaxTries = 8'(MAX_TRIES);

  cmd_t       cmd_q;
  logic       cmd_valid_q;
  res_t       res_q;
  res_t       res_d;
  logic       res_valid_q;
  meta_t      meta_q;
  store_upd_t upd;
  logic       advance;
  logic       accept;

  assign advance     = !res_valid_q || res_o.ready;
  assign cmd_i.ready = !cmd_valid_q || advance;
  assign accept      = cmd_i.valid && cmd_i.ready;

  abs_exec #(
    .MAX_PRIORITY(MAX_PRIORITY),
    .MAX_TRIES   (MAX_TRIES)
  ) u_exec (
    .cmd_i  (cmd_q),
    .store_i(meta_q),
    .res_o  (res_d),
    .upd_o  (upd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
      meta_q      <= meta_defaults(MaxPri, MaxTries);
    end else begin
      if (accept) begin
        cmd_valid_q <= 1'b1;
      end else if (advance) begin
        cmd_valid_q <= 1'b0;
      end
      if (advance) begin
        res_valid_q <= cmd_valid_q;
        if (cmd_valid_q && upd.we) begin
          meta_q <= upd.meta;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q.command       <= cmd_i.command;
      cmd_q.slot          <= cmd_i.slot;
      cmd_q.update_store  <= cmd_i.update_store;
      cmd_q.enable_flag   <= cmd_i.enable_flag;
      cmd_q.load_priority <= cmd_i.load_priority;
      cmd_q.load_tries    <= cmd_i.load_tries;
      cmd_q.load_success  <= cmd_i.load_success;
      cmd_q.load_oneshot  <= cmd_i.load_oneshot;
      cmd_q.load_valid    <= cmd_i.load_valid;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid             = res_valid_q;
  assign res_o.status            = res_q.status;
  assign res_o.boot_slot         = res_q.boot_slot;
  assign res_o.marked_successful = res_q.marked_successful;
  assign res_o.slot_bootable     = res_q.slot_bootable;
  assign res_o.slot_active       = res_q.slot_active;
  assign res_o.tries_left        = res_q.tries_left;
  assign res_o.changed           = res_q.changed;

endmodule

FILE: tb/ab_boot_slot_selector_chk.sv
module ab_boot_slot_selector_chk import abs_pkg::*; #(
  parameter int MAX_PRIORITY = 15,
  parameter int MAX_TRIES    = 7
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  abs_cmd_if        cmd_i,
  abs_res_if        res_i,
  output int        err_cnt_o,
  output int        pending_o
);

  localparam logic [7:0] MaxPri   = 8'(MAX_PRIORITY);
  localparam logic [7:0] MaxTries = 8'(MAX_TRIES);

  meta_t boot_meta;
  res_t  res_due[$];
  int    err_cnt;

  function automatic meta_t meta_init();
    meta_t m;
    m          = '0;
    m.pri[0]   = MaxPri;
    m.pri[1]   = MaxPri - 8'd1;
    m.tries[0] = MaxTries;
    m.tries[1] = MaxTries;
    return m;
  endfunction

  function automatic meta_t clear_slot(input meta_t m, input int s);
    meta_t r;
    r          = m;
    r.pri[s]   = 8'd0;
    r.tries[s] = 8'd0;
    r.succ[s]  = 1'b0;
    return r;
  endfunction

  function automatic meta_t tidy_slot(input meta_t m, input int s);
    meta_t r;
    r = m;
    if (r.pri[s] == 8'd0) begin
      return clear_slot(r, s);
    end
    if (r.tries[s] == 8'd0 && !r.succ[s]) r = clear_slot(r, s);
    if (r.tries[s] != 8'd0 && r.succ[s]) begin
      r.tries[s] = MaxTries;
      r.succ[s]  = 1'b0;
    end
    if (r.pri[s] > MaxPri) r.pri[s] = MaxPri;
    if (r.tries[s] > MaxTries) r.tries[s] = MaxTries;
    return r;
  endfunction

  function automatic logic can_boot(input meta_t m, input int s);
    return (m.pri[s] != 8'd0) && (m.succ[s] || m.tries[s] != 8'd0);
  endfunction

  function automatic logic [1:0] pick_slot(input meta_t m);
    int s;
    s = (m.pri[1] > m.pri[0]) ? 1 : 0;
    return can_boot(m, s) ? 2'(s) : SlotR;
  endfunction

  // write back the working copy, flag whether the stored image differs
  function automatic logic commit_meta(input meta_t w);
    logic diff;
    diff      = (w != boot_meta);
    boot_meta = w;
    return diff;
  endfunction

  function automatic res_t run_command(input cmd_t c);
    res_t       r;
    meta_t      w;
    int         s;
    logic [1:0] pick;
    r = '0;
    w = tidy_slot(tidy_slot(boot_meta, 0), 1);
    s = int'(c.slot);
    case (c.command)
      CmdBootSelect: begin
        if (w.os && c.update_store) begin
          w.os        = 1'b0;
          r.changed   = commit_meta(w);
          r.boot_slot = SlotR;
        end else begin
          pick        = pick_slot(w);
          r.boot_slot = pick;
          if (pick != SlotR) begin
            r.marked_successful = w.succ[pick];
            if (c.update_store && !w.succ[pick]) w.tries[pick] = w.tries[pick] - 8'd1;
          end
          if (c.update_store) r.changed = commit_meta(w);
        end
      end
      CmdMarkActive: begin
        if (s > 1) begin
          r.status = 1'b1;
        end else begin
          w.pri[s]   = MaxPri;
          w.tries[s] = MaxTries;
          w.succ[s]  = 1'b0;
          if (w.pri[1 - s] == MaxPri) w.pri[1 - s] = MaxPri - 8'd1;
          r.changed = commit_meta(w);
        end
      end
      CmdUnbootable: begin
        if (s > 1) begin
          r.status = 1'b1;
        end else begin
          r.changed = commit_meta(clear_slot(w, s));
        end
      end
      CmdSuccessful: begin
        if (s > 1) begin
          r.status = 1'b1;
        end else if (!can_boot(w, s)) begin
          r.status = 1'b1;
        end else begin
          w.tries[s] = 8'd0;
          w.succ[s]  = 1'b1;
          r.changed  = commit_meta(w);
        end
      end
      CmdSlotInfo: begin
        if (c.slot == SlotInvalid) begin
          r.status = 1'b1;
        end else begin
          r.slot_active = (pick_slot(w) == c.slot);
          if (c.slot == SlotR) begin
            r.slot_bootable     = 1'b1;
            r.marked_successful = 1'b1;
          end else begin
            r.slot_bootable     = can_boot(w, s);
            r.marked_successful = w.succ[s];
            r.tries_left        = w.tries[s];
          end
        end
      end
      CmdOneShot: begin
        w.os      = c.enable_flag;
        r.changed = commit_meta(w);
      end
      CmdLoad: begin
        if (!c.load_valid) begin
          r.changed = commit_meta(meta_init());
        end else if (s > 1) begin
          r.status = 1'b1;
        end else begin
          w          = boot_meta;
          w.pri[s]   = c.load_priority;
          w.tries[s] = c.load_tries;
          w.succ[s]  = c.load_success;
          w.os       = c.load_oneshot;
          r.changed  = commit_meta(w);
        end
      end
      default: r.status = 1'b1;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t want;
    res_t got;
    cmd_t c;
    if (!rst_ni) begin
      boot_meta = meta_init();
      res_due.delete();
      err_cnt = 0;
      err_cnt_o <= 0;
      pending_o <= 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        got.status            = res_i.status;
        got.boot_slot         = res_i.boot_slot;
        got.marked_successful = res_i.marked_successful;
        got.slot_bootable     = res_i.slot_bootable;
        got.slot_active       = res_i.slot_active;
        got.tries_left        = res_i.tries_left;
        got.changed           = res_i.changed;
        if (res_due.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10) $display("unexpected result transfer at %0t", $realtime);
        end else begin
          want = res_due.pop_front();
          if (got.status !== want.status || got.boot_slot !== want.boot_slot ||
              got.marked_successful !== want.marked_successful ||
              got.slot_bootable !== want.slot_bootable ||
              got.slot_active !== want.slot_active ||
              got.tries_left !== want.tries_left || got.changed !== want.changed) begin
            err_cnt++;
            if (err_cnt <= 10) begin
              $display("mismatch at %0t: exp st=%0d bs=%0d ms=%0d bt=%0d ac=%0d tl=%0d ch=%0d",
                       $realtime, want.status, want.boot_slot, want.marked_successful,
                       want.slot_bootable, want.slot_active, want.tries_left, want.changed);
              $display("  got st=%0d bs=%0d ms=%0d bt=%0d ac=%0d tl=%0d ch=%0d",
                       got.status, got.boot_slot, got.marked_successful,
                       got.slot_bootable, got.slot_active, got.tries_left, got.changed);
            end
          end
        end
      end
      if (cmd_i.valid && cmd_i.ready) begin
        c.command       = cmd_i.command;
        c.slot          = cmd_i.slot;
        c.update_store  = cmd_i.update_store;
        c.enable_flag   = cmd_i.enable_flag;
        c.load_priority = cmd_i.load_priority;
        c.load_tries    = cmd_i.load_tries;
        c.load_success  = cmd_i.load_success;
        c.load_oneshot  = cmd_i.load_oneshot;
        c.load_valid    = cmd_i.load_valid;
        res_due.push_back(run_command(c));
      end
      err_cnt_o <= err_cnt;
      pending_o <= res_due.size();
    end
  end

endmodule

FILE: tb/ab_boot_slot_selector_tb.sv
module ab_boot_slot_selector_tb import abs_pkg::*; ();

  localparam int MaxPriority = 15;
  localparam int MaxTries    = 7;
  localparam int NumRandom   = 1375;
  localparam int HoldCycles  = 300;
  localparam int CycleLimit  = 400000;

  logic clk_i;
  logic rst_ni;
  int   err_cnt;
  int   pending;
  int   cycles   = 0;
  int   hold_req = 0;
  int   burst_left = 0;

  abs_cmd_if cmd_if();
  abs_res_if res_if();

  ab_boot_slot_selector #(
    .MAX_PRIORITY (MaxPriority),
    .MAX_TRIES    (MaxTries)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_if),
    .res_o  (res_if)
  );

  ab_boot_slot_selector_chk #(
    .MAX_PRIORITY (MaxPriority),
    .MAX_TRIES    (MaxTries)
  ) u_chk (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd_if),
    .res_i     (res_if),
    .err_cnt_o (err_cnt),
    .pending_o (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic cmd_t make_cmd(input cmd_e op, input logic [1:0] slot, input logic upd,
                                    input logic en, input logic [7:0] pri,
                                    input logic [7:0] tries, input logic succ,
                                    input logic os, input logic lv);
    cmd_t c;
    c.command       = op;
    c.slot          = slot;
    c.update_store  = upd;
    c.enable_flag   = en;
    c.load_priority = pri;
    c.load_tries    = tries;
    c.load_success  = succ;
    c.load_oneshot  = os;
    c.load_valid    = lv;
    return c;
  endfunction

  function automatic logic [7:0] pick_byte(input int max_val);
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'(max_val);
      3:       return 8'(max_val + 1);
      4:       return 8'hff;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int   pick;
    pick            = $urandom_range(0, 99);
    c.slot          = ($urandom_range(0, 9) < 7) ? 2'($urandom_range(0, 1))
                                                 : 2'($urandom_range(2, 3));
    c.update_store  = ($urandom_range(0, 3) != 0);
    c.enable_flag   = 1'($urandom_range(0, 1));
    c.load_priority = pick_byte(MaxPriority);
    c.load_tries    = pick_byte(MaxTries);
    c.load_success  = 1'($urandom_range(0, 1));
    c.load_oneshot  = 1'($urandom_range(0, 1));
    c.load_valid    = ($urandom_range(0, 9) != 0);
    if (pick < 30)      c.command = CmdBootSelect;
    else if (pick < 40) c.command = CmdMarkActive;
    else if (pick < 47) c.command = CmdUnbootable;
    else if (pick < 57) c.command = CmdSuccessful;
    else if (pick < 72) c.command = CmdSlotInfo;
    else if (pick < 78) c.command = CmdOneShot;
    else if (pick < 97) c.command = CmdLoad;
    else                c.command = CmdUnused;
    return c;
  endfunction

  // hold valid through back-to-back bursts, drop it only for a gap
  task automatic send_cmd(input cmd_t c);
    int gap;
    cmd_if.valid         <= 1'b1;
    cmd_if.command       <= c.command;
    cmd_if.slot          <= c.slot;
    cmd_if.update_store  <= c.update_store;
    cmd_if.enable_flag   <= c.enable_flag;
    cmd_if.load_priority <= c.load_priority;
    cmd_if.load_tries    <= c.load_tries;
    cmd_if.load_success  <= c.load_success;
    cmd_if.load_oneshot  <= c.load_oneshot;
    cmd_if.load_valid    <= c.load_valid;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        cmd_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic wait_drained();
    cmd_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int seg_len;
    int mode;
    int holds_served;
    int held;
    seg_len      = 0;
    mode         = 0;
    holds_served = 0;
    forever begin
      if (holds_served < hold_req) begin
        holds_served++;
        res_if.ready <= 1'b0;
        for (held = 0; held < HoldCycles; held++) @(posedge clk_i);
      end else begin
        if (seg_len == 0) begin
          mode    = $urandom_range(0, 3);
          seg_len = $urandom_range(10, 120);
        end
        seg_len--;
        case (mode)
          0:       res_if.ready <= 1'b1;
          1:       res_if.ready <= 1'($urandom_range(0, 1));
          2:       res_if.ready <= ($urandom_range(0, 9) != 0);
          default: res_if.ready <= (seg_len % 4 == 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  initial begin
    int i;
    rst_ni <= 1'b0;
    cmd_if.valid         <= 1'b0;
    cmd_if.command       <= CmdBootSelect;
    cmd_if.slot          <= SlotA;
    cmd_if.update_store  <= 1'b0;
    cmd_if.enable_flag   <= 1'b0;
    cmd_if.load_priority <= 8'd0;
    cmd_if.load_tries    <= 8'd0;
    cmd_if.load_success  <= 1'b0;
    cmd_if.load_oneshot  <= 1'b0;
    cmd_if.load_valid    <= 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_cmd(make_cmd(CmdSlotInfo,   SlotA,       0, 0, 8'd0,   8'd0,   0, 0, 1));
    send_cmd(make_cmd(CmdSlotInfo,   SlotR,       0, 0, 8'd0,   8'd0,   0, 0, 1));
    send_cmd(make_cmd(CmdSlotInfo,   SlotInvalid, 1, 1, 8'hff,  8'hff,  1, 1, 1));
    send_cmd(make_cmd(CmdBootSelect, SlotInvalid, 0, 0, 8'd0,   8'd0,   0, 0, 1));
    send_cmd(make_cmd(CmdBootSelect, SlotA,       1, 0, 8'd0,   8'd0,   0, 0, 1));
    send_cmd(make_cmd(CmdSuccessful, SlotA,       0, 0, 8'd0,   8'd0,   0, 0, 1));
    send_cmd(make_cmd(CmdSlotInfo,   SlotA,       0, 0, 8'd0,   8'd0,   0, 0, 1));
    send_cmd(make_cmd(CmdSuccessful, SlotR,       0, 0, 8'd0,   8'd0,   0, 0, 1));
    send_cmd(make_cmd(CmdMarkActive, SlotB,       0, 0, 8'd0,   8'd0,   0, 0, 1));
    send_cmd(make_cmd(CmdBootSelect, SlotA,       1, 0, 8'd0,   8'd0,   0, 0, 1));
    send_cmd(make_cmd(CmdUnbootable, SlotA,       0, 0, 8'd0,   8'd0,   0, 0, 1));
    send_cmd(make_cmd(CmdSuccessful, SlotA,       0, 0, 8'd0,   8'd0,   0, 0, 1));
    send_cmd(make_cmd(CmdUnbootable, SlotB,       0, 0, 8'd0,   8'd0,   0, 0, 1));
    send_cmd(make_cmd(CmdBootSelect, SlotB,       1, 0, 8'd0,   8'd0,   0, 0, 1));
    send_cmd(make_cmd(CmdSlotInfo,   SlotR,       0, 0, 8'd0,   8'd0,   0, 0, 1));
    send_cmd(make_cmd(CmdOneShot,    SlotInvalid, 0, 1, 8'd0,   8'd0,   0, 0, 1));
    send_cmd(make_cmd(CmdBootSelect, SlotA,       0, 0, 8'd0,   8'd0,   0, 0, 1));
    send_cmd(make_cmd(CmdBootSelect, SlotA,       1, 0, 8'd0,   8'd0,   0, 0, 1));
    send_cmd(make_cmd(CmdLoad,       SlotA,       0, 0, 8'hff,  8'hff,  1, 1, 1));
    send_cmd(make_cmd(CmdSlotInfo,   SlotA,       0, 0, 8'd0,   8'd0,   0, 0, 1));
    send_cmd(make_cmd(CmdLoad,       SlotR,       0, 0, 8'd5,   8'd3,   0, 1, 1));
    send_cmd(make_cmd(CmdMarkActive, SlotInvalid, 0, 0, 8'd0,   8'd0,   0, 0, 1));
    send_cmd(make_cmd(CmdUnbootable, SlotR,       0, 0, 8'd0,   8'd0,   0, 0, 1));
    send_cmd(make_cmd(CmdLoad,       SlotInvalid, 0, 0, 8'd9,   8'd9,   1, 1, 0));
    send_cmd(make_cmd(CmdUnused,     SlotB,       1, 1, 8'hff,  8'hff,  1, 1, 1));
    send_cmd(make_cmd(CmdLoad,       SlotA,       0, 0, 8'd200, 8'd0,   0, 0, 1));
    send_cmd(make_cmd(CmdBootSelect, SlotA,       1, 0, 8'd0,   8'd0,   0, 0, 1));
    wait_drained();

    for (i = 0; i < NumRandom; i++) begin
      if (i == 200 || i == 900) hold_req <= hold_req + 1;
      if (i % 350 == 349) wait_drained();
      send_cmd(rand_cmd());
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
